// ===== rtl/core/sgr_pkg.sv =====
// Package for the ANSI SGR color extractor: payload structs, sizes, byte codes
// and the SGR field decoder. No dependencies; imported by the top level.

package sgr_pkg;

	// Color pair table and line geometry
	localparam int PAIR_DEPTH = 256;
	localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
	localparam int CNT_W      = $clog2(PAIR_DEPTH + 1);
	localparam int MAX_LINE   = 4096;
	localparam int POS_W      = 13;
	localparam int PAIR_IDX_W = 8;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_COLORS_ENABLED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_CAPACITY = 1'd1;

	// Parser phases
	localparam logic [1:0] PH_TEXT = 2'd0;
	localparam logic [1:0] PH_ESC  = 2'd1;
	localparam logic [1:0] PH_CSI  = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_RUN  = 2'd1;
	localparam logic [1:0] KIND_EOL  = 2'd2;

	// Attribute codes
	localparam logic [2:0] ATTR_NONE      = 3'd0;
	localparam logic [2:0] ATTR_BOLD      = 3'd1;
	localparam logic [2:0] ATTR_UNDERLINE = 3'd2;
	localparam logic [2:0] ATTR_BLINK     = 3'd3;
	localparam logic [2:0] ATTR_REVERSE   = 3'd4;

	localparam logic [3:0] NO_COLOR = 4'hF;

	// Byte codes
	localparam logic [7:0] CH_ESC    = 8'd27;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_M      = 8'h6D;

	// SGR parameter codes
	localparam logic [7:0] SGR_FG_LO     = 8'd30;
	localparam logic [7:0] SGR_FG_HI     = 8'd37;
	localparam logic [7:0] SGR_BG_LO     = 8'd40;
	localparam logic [7:0] SGR_BG_HI     = 8'd47;
	localparam logic [7:0] SGR_BOLD      = 8'd1;
	localparam logic [7:0] SGR_UNDERLINE = 8'd4;
	localparam logic [7:0] SGR_BLINK     = 8'd5;
	localparam logic [7:0] SGR_REVERSE   = 8'd7;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       line_end;
	} char_req_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [7:0]            text_byte;
		logic [POS_W-1:0]      position;
		logic [PAIR_IDX_W-1:0] pair_index;
		logic [2:0]            attribute;
		logic                  last;
	} rec_t;

	// Pending colors and attribute of an open sequence
	typedef struct packed {
		logic [3:0] fg;
		logic [3:0] bg;
		logic [2:0] attr;
	} sgr_t;

	localparam sgr_t SGR_IDLE = '{fg: NO_COLOR, bg: NO_COLOR, attr: ATTR_NONE};

	// Apply one closed field value to the pending set; unknown values change nothing
	function automatic sgr_t sgr_close(input logic [7:0] v, input sgr_t cur);
		sgr_t r;
		r = cur;
		priority if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
			r.bg = 4'(v - SGR_BG_LO);
		end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
			r.fg = 4'(v - SGR_FG_LO);
		end else if (v == SGR_BOLD) begin
			r.attr = ATTR_BOLD;
		end else if (v == SGR_UNDERLINE) begin
			r.attr = ATTR_UNDERLINE;
		end else if (v == SGR_BLINK) begin
			r.attr = ATTR_BLINK;
		end else if (v == SGR_REVERSE) begin
			r.attr = ATTR_REVERSE;
		end else begin
			r = cur;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/ansi_sgr_color_extractor.sv =====
// Top level of the ANSI SGR color extractor: escape parser, color pair table
// memory with its scan sequencer, and the result queue. Depends on sgr_pkg.

// Usage
//   byte_valid/byte_ready/byte_req carry one raw line byte per request, with
//   line_end set on the last byte of a line. rec_valid/rec_ready/rec return
//   text bytes, color run starts and end-of-line records, in order; 'last'
//   marks the final record caused by one request. cfg_valid/cfg_ready with
//   cfg_index/cfg_data write colors_enabled (index 0) and table_capacity
//   (index 1); cfg_ready is always high, write only while the block is idle.
// Flow
//   Records are registered into a four-entry queue. Ordinary bytes go at one
//   per cycle while the queue has two free slots. An 'm' terminator with
//   colors enabled walks the pair table through its single read port: an
//   exact search, then a fuzzy search when the table holds table_capacity
//   pairs. No request is taken during a walk.
// Reset
//   Clears the parser, the line offset, the pair count and the queue; the
//   table memory is not cleared, only entries below the pair count are read.
// Stall
//   A stalled receiver holds the queue head; byte_ready drops once fewer than
//   two queue slots are free.

module ansi_sgr_color_extractor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_ready,
	input  sgr_pkg::char_req_t            byte_req,
	output logic                          rec_valid,
	input  logic                          rec_ready,
	output sgr_pkg::rec_t                 rec,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sgr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sgr_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXACT = 2'd1;
	localparam logic [1:0] ST_FUZZY = 2'd2;

	// Configuration
	logic                  colors_q;
	logic [CFG_DATA_W-1:0] cap_q;
	logic [CNT_W-1:0]      cap_eff;

	// Parser state
	logic [1:0]       phase_q, ph_n;
	logic [7:0]       acc_q, acc_n;
	logic             stop_q, stop_n;
	sgr_t             pend_q, pend_n;
	logic [POS_W-1:0] off_q, off_n;

	// Table walk
	logic [1:0]       state_q, state_n;
	logic [CNT_W-1:0] scan_q, scan_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [7:0]       want_q, want_n;
	logic [POS_W-1:0] run_pos_q, run_pos_n;
	logic [2:0]       run_attr_q, run_attr_n;
	logic             eol_pend_q, eol_pend_n;
	logic [POS_W-1:0] eol_pos_q, eol_pos_n;

	// Pair table memory
	logic [7:0]         pair_mem [PAIR_DEPTH];
	logic               rd_en, wr_en;
	logic [PAIR_AW-1:0] rd_addr;
	logic [7:0]         rdata_s1;
	logic               rd_vld_s1, rd_vld_n;
	logic [PAIR_AW-1:0] rd_idx_s1;

	// Result queue
	rec_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pa, pb, pop;
	rec_t               ra, rb;
	logic [FIFO_CW-1:0] npush;

	assign cfg_ready  = 1'b1;
	assign byte_ready = (state_q == ST_IDLE) && (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign rec_valid  = (count_q != '0);
	assign rec        = fifo_q[rptr_q];
	assign pop        = rec_valid && rec_ready;
	assign npush      = FIFO_CW'(pa) + FIFO_CW'(pb);

	// A capacity of zero or beyond the table counts as the whole table
	always_comb begin
		if (cap_q == '0 || 32'(cap_q) > PAIR_DEPTH) begin
			cap_eff = CNT_W'(PAIR_DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	always_comb begin
		logic [7:0]       c;
		logic             consumed;
		logic             text_go;
		logic             is_m;
		logic [11:0]      dv;
		sgr_t             cl;
		logic             hit;
		logic             done;
		logic [PAIR_AW-1:0] done_idx;
		logic [CNT_W-1:0] scan_dec;
		logic             fz_match;

		c        = byte_req.char_byte;
		consumed = 1'b0;
		text_go  = 1'b0;
		is_m     = 1'b0;
		dv       = 12'({4'd0, acc_q}) * 12'd10 + 12'(c - CH_0);
		cl       = sgr_close(acc_q, pend_q);
		hit      = 1'b0;
		done     = 1'b0;
		done_idx = '0;
		scan_dec = scan_q - CNT_W'(1);
		fz_match = (rdata_s1[7:4] == want_q[7:4] && rdata_s1[3:0] == NO_COLOR) ||
			(rdata_s1[7:4] == NO_COLOR && rdata_s1[3:0] == want_q[3:0]);

		ph_n       = phase_q;
		acc_n      = acc_q;
		stop_n     = stop_q;
		pend_n     = pend_q;
		off_n      = off_q;
		state_n    = state_q;
		scan_n     = scan_q;
		cnt_n      = cnt_q;
		want_n     = want_q;
		run_pos_n  = run_pos_q;
		run_attr_n = run_attr_q;
		eol_pend_n = eol_pend_q;
		eol_pos_n  = eol_pos_q;
		rd_vld_n   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		pa         = 1'b0;
		pb         = 1'b0;
		ra         = '0;
		rb         = '0;

		unique case (state_q)
			ST_EXACT: begin
				// First hit in ascending order wins; read of entry i overlaps compare of i-1
				hit = rd_vld_s1 && (rdata_s1 == want_q);
				if (hit) begin
					done     = 1'b1;
					done_idx = rd_idx_s1;
				end else if (scan_q != cnt_q) begin
					rd_en    = 1'b1;
					rd_addr  = scan_q[PAIR_AW-1:0];
					rd_vld_n = 1'b1;
					scan_n   = scan_q + CNT_W'(1);
				end else if (!rd_vld_s1) begin
					if (cnt_q >= cap_eff) begin
						state_n = ST_FUZZY;
						scan_n  = cnt_q;
					end else begin
						// Insert the new pair at the fill point
						wr_en    = 1'b1;
						cnt_n    = cnt_q + CNT_W'(1);
						done     = 1'b1;
						done_idx = cnt_q[PAIR_AW-1:0];
					end
				end
			end
			ST_FUZZY: begin
				// Walk from the newest entry down; none found falls back to pair 0
				hit = rd_vld_s1 && fz_match;
				if (hit) begin
					done     = 1'b1;
					done_idx = rd_idx_s1;
				end else if (scan_q != '0) begin
					rd_en    = 1'b1;
					rd_addr  = scan_dec[PAIR_AW-1:0];
					rd_vld_n = 1'b1;
					scan_n   = scan_dec;
				end else if (!rd_vld_s1) begin
					done     = 1'b1;
					done_idx = '0;
				end
			end
			default: begin
				if (byte_valid && byte_ready) begin
					if (phase_q == PH_ESC) begin
						if (c == CH_LBRACK) begin
							ph_n     = PH_CSI;
							acc_n    = '0;
							stop_n   = 1'b0;
							pend_n   = SGR_IDLE;
							consumed = 1'b1;
						end else begin
							// Lone escape: drop it, handle this byte as text
							ph_n = PH_TEXT;
						end
					end else if (phase_q == PH_CSI) begin
						consumed = 1'b1;
						if (c >= CH_LA && c <= CH_LZ) begin
							if (c == CH_M) begin
								is_m   = 1'b1;
								pend_n = cl;
								acc_n  = '0;
								stop_n = 1'b0;
							end
							ph_n = PH_TEXT;
						end else if (c == CH_SEMI) begin
							pend_n = cl;
							acc_n  = '0;
							stop_n = 1'b0;
						end else if (c >= CH_0 && c <= CH_9) begin
							if (!stop_q) begin
								acc_n = (dv > 12'd255) ? 8'hFF : dv[7:0];
							end
						end else begin
							stop_n = 1'b1;
						end
					end

					if (!consumed) begin
						if (c == CH_ESC) begin
							ph_n = PH_ESC;
						end else begin
							ph_n = PH_TEXT;
							if (off_q < POS_W'(MAX_LINE)) begin
								text_go = 1'b1;
								off_n   = off_q + POS_W'(1);
							end
						end
					end

					eol_pos_n = off_n;

					if (byte_req.line_end) begin
						ph_n   = PH_TEXT;
						acc_n  = '0;
						stop_n = 1'b0;
						pend_n = SGR_IDLE;
						off_n  = '0;
					end

					rb = '{kind: KIND_EOL, text_byte: '0, position: eol_pos_n,
						pair_index: '0, attribute: ATTR_NONE, last: 1'b1};

					if (is_m) begin
						if (colors_q) begin
							state_n    = ST_EXACT;
							scan_n     = '0;
							want_n     = {cl.fg, cl.bg};
							run_pos_n  = off_q;
							run_attr_n = cl.attr;
							eol_pend_n = byte_req.line_end;
						end else begin
							pa = 1'b1;
							ra = '{kind: KIND_RUN, text_byte: '0, position: off_q,
								pair_index: '0, attribute: cl.attr,
								last: !byte_req.line_end};
							pb = byte_req.line_end;
						end
					end else if (text_go) begin
						pa = 1'b1;
						ra = '{kind: KIND_TEXT, text_byte: c, position: off_q,
							pair_index: '0, attribute: ATTR_NONE,
							last: !byte_req.line_end};
						pb = byte_req.line_end;
					end else if (byte_req.line_end) begin
						pa = 1'b1;
						ra = rb;
					end
				end
			end
		endcase

		if (done) begin
			state_n = ST_IDLE;
			pa = 1'b1;
			ra = '{kind: KIND_RUN, text_byte: '0, position: run_pos_q,
				pair_index: PAIR_IDX_W'(done_idx), attribute: run_attr_q,
				last: !eol_pend_q};
			pb = eol_pend_q;
			rb = '{kind: KIND_EOL, text_byte: '0, position: eol_pos_q,
				pair_index: '0, attribute: ATTR_NONE, last: 1'b1};
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q   <= 1'b1;
			cap_q      <= CFG_DATA_W'(64);
			phase_q    <= PH_TEXT;
			acc_q      <= '0;
			stop_q     <= 1'b0;
			pend_q     <= SGR_IDLE;
			off_q      <= '0;
			state_q    <= ST_IDLE;
			scan_q     <= '0;
			cnt_q      <= '0;
			eol_pend_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
			wptr_q     <= '0;
			rptr_q     <= '0;
			count_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_COLORS_ENABLED: colors_q <= cfg_data[0];
					REG_TABLE_CAPACITY: cap_q    <= cfg_data;
				endcase
			end
			phase_q    <= ph_n;
			acc_q      <= acc_n;
			stop_q     <= stop_n;
			pend_q     <= pend_n;
			off_q      <= off_n;
			state_q    <= state_n;
			scan_q     <= scan_n;
			cnt_q      <= cnt_n;
			eol_pend_q <= eol_pend_n;
			rd_vld_s1  <= rd_vld_n;
			wptr_q     <= wptr_q + FIFO_AW'(npush);
			rptr_q     <= rptr_q + FIFO_AW'(pop);
			count_q    <= count_q + npush - FIFO_CW'(pop);
		end
	end

	// Request payload held for the table walk
	always_ff @(posedge clk) begin
		want_q     <= want_n;
		run_pos_q  <= run_pos_n;
		run_attr_q <= run_attr_n;
		eol_pos_q  <= eol_pos_n;
		if (rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
	end

	// Pair table: one write and one registered read per cycle. Walks run one at
	// a time, so a write always lands before any later read of that entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pair_mem[cnt_q[PAIR_AW-1:0]] <= want_q;
		end
		if (rd_en) begin
			rdata_s1 <= pair_mem[rd_addr];
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (pa) begin
			fifo_q[wptr_q] <= ra;
		end
		if (pb) begin
			fifo_q[wptr_q + FIFO_AW'(1)] <= rb;
		end
	end

`ifndef SYNTH
	// Queue never overflows: requests are taken only with two slots free
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overflow");

	// Every table read addresses a filled entry
	a_read_filled: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CNT_W'(rd_idx_s1) < cnt_q))
		else $error("read of unfilled pair entry");

	// Fuzzy walk starts only on a table at its capacity
	a_fuzzy_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FUZZY && $past(state_q) == ST_EXACT) |-> (cnt_q >= cap_eff))
		else $error("fuzzy walk on a table with room");

	// Pair count grows only at the end of an exact walk, by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			($past(state_q) == ST_EXACT && cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("pair count changed outside insert");
`endif

endmodule
